// ===== rtl/register_bank_allocator_assert.svh =====
// Assertion macros for the register bank allocator
`ifndef REGISTER_BANK_ALLOCATOR_ASSERT_SVH
`define REGISTER_BANK_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF

`define RBA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("register_bank_allocator: same-cycle check failed");

`define RBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("register_bank_allocator: next-cycle check failed");

`else

`define RBA_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define RBA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/rba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rba_pkg;

   localparam int NUM_REGS_DEF    = 8;
   localparam int VAR_ID_BITS_DEF = 8;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      OUT_HIT     = 2'd0,
      OUT_PLACED  = 2'd1,
      OUT_EVICTED = 2'd2,
      OUT_FREED   = 2'd3
   } outcome_type;

   // state of the request stage as seen by the lookup logic
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctrl_type;

   typedef struct packed {
      outcome_type outcome;
      logic        spill_valid;
      logic        fill_valid;
   } rsp_flags_type;

endpackage

`default_nettype wire

// ===== rtl/rba_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rba_in_reg
   import rba_pkg::*;
#(
   parameter int NUM_REGS    = NUM_REGS_DEF,
   parameter int VAR_ID_BITS = VAR_ID_BITS_DEF,
   parameter int IDX_BITS    = $clog2(NUM_REGS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept_en,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire opcode_type             req_opcode,
   input  wire logic [VAR_ID_BITS-1:0] req_var_id,
   input  wire logic [IDX_BITS-1:0]    req_free_reg,
   input  wire logic                   advance,
   output      stage_ctrl_type         ctrl,
   output      opcode_type             opcode,
   output      logic [VAR_ID_BITS-1:0] var_id,
   output      logic [IDX_BITS-1:0]    free_reg
);

   logic                   vld_ff;
   logic                   vld_in;
   opcode_type             opcode_ff;
   logic [VAR_ID_BITS-1:0] var_id_ff;
   logic [IDX_BITS-1:0]    free_reg_ff;

   assign req_tready = accept_en && (!vld_ff || advance);
   assign vld_in     = req_tready ? req_tvalid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         opcode_ff   <= req_opcode;
         var_id_ff   <= req_var_id;
         free_reg_ff <= req_free_reg;
      end
   end

   assign ctrl.valid   = vld_ff;
   assign ctrl.advance = advance;
   assign opcode       = opcode_ff;
   assign var_id       = var_id_ff;
   assign free_reg     = free_reg_ff;

endmodule

`default_nettype wire

// ===== rtl/rba_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "register_bank_allocator_assert.svh"

module rba_core
   import rba_pkg::*;
#(
   parameter int NUM_REGS    = NUM_REGS_DEF,
   parameter int VAR_ID_BITS = VAR_ID_BITS_DEF,
   parameter int IDX_BITS    = $clog2(NUM_REGS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_accept,
   input  wire logic [VAR_ID_BITS-1:0] req_var_id,
   output      logic                   mark_ready,
   input  wire stage_ctrl_type         ctrl,
   input  wire opcode_type             opcode,
   input  wire logic [VAR_ID_BITS-1:0] var_id,
   input  wire logic [IDX_BITS-1:0]    free_reg,
   input  wire logic                   spill_enable,
   output      logic [IDX_BITS-1:0]    res_idx,
   output      rsp_flags_type          flags,
   output      logic [VAR_ID_BITS-1:0] spill_var
);

   localparam int MARK_DEPTH = 1 << VAR_ID_BITS;
   localparam logic [IDX_BITS:0]   NUM_REGS_W = (IDX_BITS + 1)'(NUM_REGS);
   localparam logic [IDX_BITS-1:0] LAST_REG   = IDX_BITS'(NUM_REGS - 1);

   logic [NUM_REGS-1:0]    valid_ff;
   logic [NUM_REGS-1:0]    valid_in;
   logic [VAR_ID_BITS-1:0] owner_ff [NUM_REGS];
   logic [VAR_ID_BITS-1:0] owner_in [NUM_REGS];
   logic [IDX_BITS-1:0]    last_used_ff;
   logic [IDX_BITS-1:0]    last_used_in;
   // owner was refilled, its spilled mark is cleared once it leaves the register
   logic [NUM_REGS-1:0]    pend_ff;
   logic [NUM_REGS-1:0]    pend_in;

   logic                   mark_mem [MARK_DEPTH];
   logic                   mark_rd_ff;
   logic                   mark_we;
   logic [VAR_ID_BITS-1:0] mark_wa;
   logic                   mark_wd;
   logic                   clear_busy_ff;
   logic                   clear_busy_in;
   logic [VAR_ID_BITS-1:0] clear_addr_ff;
   logic [VAR_ID_BITS-1:0] clear_addr_in;

   logic                   fire;
   logic                   alloc_fire;
   logic [NUM_REGS-1:0]    hit_vec;
   logic                   hit_any;
   logic [IDX_BITS-1:0]    hit_idx;
   logic                   free_any;
   logic [IDX_BITS-1:0]    free_idx;
   logic [IDX_BITS-1:0]    victim;
   logic [VAR_ID_BITS-1:0] victim_owner;
   logic                   place;
   logic                   evicting;
   logic                   free_ok;

   assign fire       = ctrl.valid && ctrl.advance;
   assign alloc_fire = fire && opcode == OP_ALLOC;

   // parallel compare, lowest match / lowest free register wins
   always_comb begin
      hit_vec  = '0;
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = NUM_REGS - 1; i >= 0; i--) begin
         hit_vec[i] = valid_ff[i] && (owner_ff[i] == var_id);
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_BITS'(i);
         end
      end
   end

   assign victim       = (last_used_ff == LAST_REG) ? '0 : last_used_ff + 1'b1;
   assign victim_owner = owner_ff[victim];
   assign place        = (opcode == OP_ALLOC) && !hit_any;
   assign evicting     = place && !free_any;
   assign free_ok      = {1'b0, free_reg} < NUM_REGS_W;

   always_comb begin
      res_idx           = free_reg;
      flags.outcome     = OUT_FREED;
      flags.spill_valid = 1'b0;
      flags.fill_valid  = 1'b0;
      spill_var         = '0;
      if (opcode == OP_ALLOC) begin
         if (hit_any) begin
            res_idx       = hit_idx;
            flags.outcome = OUT_HIT;
         end else if (free_any) begin
            res_idx          = free_idx;
            flags.outcome    = OUT_PLACED;
            flags.fill_valid = spill_enable && mark_rd_ff;
         end else begin
            res_idx           = victim;
            flags.outcome     = OUT_EVICTED;
            flags.spill_valid = spill_enable;
            spill_var         = spill_enable ? victim_owner : '0;
            flags.fill_valid  = spill_enable && mark_rd_ff;
         end
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      owner_in     = owner_ff;
      last_used_in = last_used_ff;
      pend_in      = pend_ff;
      if (fire) begin
         if (opcode == OP_FREE) begin
            for (int i = 0; i < NUM_REGS; i++) begin
               if (free_ok && free_reg == IDX_BITS'(i)) begin
                  valid_in[i] = 1'b0;
                  pend_in[i]  = 1'b0;
               end
            end
         end else begin
            last_used_in = res_idx;
            if (place) begin
               valid_in[res_idx] = 1'b1;
               owner_in[res_idx] = var_id;
               pend_in[res_idx]  = flags.fill_valid;
            end
         end
      end
   end

   // one mark write per cycle: clearing pass, deferred clear or spill set
   always_comb begin
      mark_we = 1'b0;
      mark_wa = clear_addr_ff;
      mark_wd = 1'b0;
      if (clear_busy_ff) begin
         mark_we = 1'b1;
      end else if (fire) begin
         if (opcode == OP_FREE) begin
            if (free_ok && valid_ff[free_reg] && pend_ff[free_reg]) begin
               mark_we = 1'b1;
               mark_wa = owner_ff[free_reg];
            end
         end else if (evicting) begin
            if (spill_enable) begin
               mark_we = 1'b1;
               mark_wa = victim_owner;
               mark_wd = 1'b1;
            end else if (pend_ff[victim]) begin
               mark_we = 1'b1;
               mark_wa = victim_owner;
            end
         end
      end
   end

   assign clear_busy_in = clear_busy_ff && (clear_addr_ff != '1);
   assign clear_addr_in = clear_busy_ff ? clear_addr_ff + 1'b1 : clear_addr_ff;
   assign mark_ready    = !clear_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // mark read as the transaction enters the request register
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (req_accept) begin
         if (mark_we && mark_wa == req_var_id) begin
            mark_rd_ff <= mark_wd;
         end else begin
            mark_rd_ff <= mark_mem[req_var_id];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         last_used_ff <= '0;
         pend_ff      <= '0;
      end else begin
         valid_ff     <= valid_in;
         last_used_ff <= last_used_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff <= owner_in;
   end

   `RBA_ASSERT_IMPLIES(a_one_hit, clock, reset, fire, $onehot0(hit_vec))
   `RBA_ASSERT_NEXT(a_alloc_valid, clock, reset, alloc_fire, valid_ff[$past(res_idx)])
   `RBA_ASSERT_NEXT(a_fill_pend, clock, reset, fire && flags.fill_valid, pend_ff[$past(res_idx)])
   `RBA_ASSERT_IMPLIES(a_spill_evict, clock, reset, fire && flags.spill_valid, evicting)
   `RBA_ASSERT_IMPLIES(a_idle_clear, clock, reset, clear_busy_ff, !ctrl.valid)

endmodule

`default_nettype wire

// ===== rtl/rba_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rba_out_reg
   import rba_pkg::*;
#(
   parameter int NUM_REGS    = NUM_REGS_DEF,
   parameter int VAR_ID_BITS = VAR_ID_BITS_DEF,
   parameter int IDX_BITS    = $clog2(NUM_REGS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   stage_valid,
   input  wire logic [IDX_BITS-1:0]    res_idx,
   input  wire rsp_flags_type          flags,
   input  wire logic [VAR_ID_BITS-1:0] spill_var,
   output      logic                   advance,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [IDX_BITS-1:0]    rsp_idx,
   output      rsp_flags_type          rsp_flags,
   output      logic [VAR_ID_BITS-1:0] rsp_spill_var
);

   logic                   vld_ff;
   logic                   vld_in;
   logic [IDX_BITS-1:0]    idx_ff;
   rsp_flags_type          flags_ff;
   logic [VAR_ID_BITS-1:0] spill_var_ff;

   assign advance = !vld_ff || rsp_tready;
   assign vld_in  = advance ? stage_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid && advance) begin
         idx_ff       <= res_idx;
         flags_ff     <= flags;
         spill_var_ff <= spill_var;
      end
   end

   assign rsp_tvalid    = vld_ff;
   assign rsp_idx       = idx_ff;
   assign rsp_flags     = flags_ff;
   assign rsp_spill_var = spill_var_ff;

endmodule

`default_nettype wire

// ===== rtl/register_bank_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Register bank allocator: maps variable ids onto NUM_REGS registers, fully
// associative, with round-robin eviction after the last-used register. Each
// request gives exactly one response transaction, which passes through the
// request register and then the response register. One request is taken every
// cycle while the response side keeps up; the rate is set by the
// combinational parallel compare of all registers and the priority pick, whose
// table update is visible to the very next request. After reset the
// spilled-mark memory is cleared one entry per cycle, and req_tready stays low
// until all 2^VAR_ID_BITS (256) entries are cleared. spill_enable resets to 1
// and should be written only while no transaction is in flight.

module register_bank_allocator
   import rba_pkg::*;
#(
   parameter int NUM_REGS    = NUM_REGS_DEF,
   parameter int VAR_ID_BITS = VAR_ID_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // var_id, free_reg
   input  wire logic [((VAR_ID_BITS + $clog2(NUM_REGS) + 7) / 8) * 8 - 1:0] req_tdata,
   // opcode
   input  wire logic                  req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // reg_index, spill_valid, spill_var, fill_valid
   output      logic [((VAR_ID_BITS + $clog2(NUM_REGS) + 9) / 8) * 8 - 1:0] rsp_tdata,
   // outcome
   output      logic [1:0]            rsp_tuser,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic                  csr_wdata
);

   localparam int IDX_BITS = $clog2(NUM_REGS);
   localparam int RSP_W    = ((VAR_ID_BITS + IDX_BITS + 9) / 8) * 8;
   localparam int RSP_BITS = VAR_ID_BITS + IDX_BITS + 2;

   logic                   spill_en_ff;
   logic                   spill_en_in;
   logic                   mark_ready;
   logic                   req_accept;
   stage_ctrl_type         ctrl;
   opcode_type             opcode;
   logic [VAR_ID_BITS-1:0] var_id;
   logic [IDX_BITS-1:0]    free_reg;
   logic                   advance;
   logic [IDX_BITS-1:0]    res_idx;
   rsp_flags_type          flags;
   logic [VAR_ID_BITS-1:0] spill_var;
   logic [IDX_BITS-1:0]    rsp_idx;
   rsp_flags_type          rsp_flags;
   logic [VAR_ID_BITS-1:0] rsp_spill_var;
   logic [RSP_BITS-1:0]    rsp_packed;

   assign csr_ready   = 1'b1;
   assign spill_en_in = csr_valid ? csr_wdata : spill_en_ff;
   assign req_accept  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         spill_en_ff <= 1'b1;
      end else begin
         spill_en_ff <= spill_en_in;
      end
   end

   rba_in_reg #(
      .NUM_REGS    (NUM_REGS),
      .VAR_ID_BITS (VAR_ID_BITS)
   ) u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .accept_en    (mark_ready),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_opcode   (opcode_type'(req_tuser)),
      .req_var_id   (req_tdata[VAR_ID_BITS-1:0]),
      .req_free_reg (req_tdata[VAR_ID_BITS +: IDX_BITS]),
      .advance      (advance),
      .ctrl         (ctrl),
      .opcode       (opcode),
      .var_id       (var_id),
      .free_reg     (free_reg)
   );

   rba_core #(
      .NUM_REGS    (NUM_REGS),
      .VAR_ID_BITS (VAR_ID_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .req_var_id   (req_tdata[VAR_ID_BITS-1:0]),
      .mark_ready   (mark_ready),
      .ctrl         (ctrl),
      .opcode       (opcode),
      .var_id       (var_id),
      .free_reg     (free_reg),
      .spill_enable (spill_en_ff),
      .res_idx      (res_idx),
      .flags        (flags),
      .spill_var    (spill_var)
   );

   rba_out_reg #(
      .NUM_REGS    (NUM_REGS),
      .VAR_ID_BITS (VAR_ID_BITS)
   ) u_out_reg (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (ctrl.valid),
      .res_idx       (res_idx),
      .flags         (flags),
      .spill_var     (spill_var),
      .advance       (advance),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_idx       (rsp_idx),
      .rsp_flags     (rsp_flags),
      .rsp_spill_var (rsp_spill_var)
   );

   assign rsp_packed = {rsp_flags.fill_valid, rsp_spill_var, rsp_flags.spill_valid, rsp_idx};
   assign rsp_tdata  = RSP_W'(rsp_packed);
   assign rsp_tuser  = rsp_flags.outcome;

endmodule

`default_nettype wire
